@@ src/test_frame_checker_top_macros.svh @@
// Assertion helpers for the test frame checker.
`ifndef TEST_FRAME_CHECKER_TOP_MACROS_SVH
`define TEST_FRAME_CHECKER_TOP_MACROS_SVH

// Same-cycle implication, masked while reset is active.
`define TFC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tfc check failed");

// Next-cycle implication, masked while reset is active.
`define TFC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tfc check failed");

`endif

@@ src/tfc_pkg.sv @@
package tfc_pkg;

    localparam logic [7:0]  SYNC_BYTE = 8'hA5;

    localparam logic        OP_BYTE = 1'b0;
    localparam logic        OP_TICK = 1'b1;

    localparam int          CFG_IDX_W  = 2;
    localparam int          CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_EXP_PAYLOAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 2'd2;

    localparam logic [23:0] RST_EXP_PAYLOAD = 24'd16384;
    localparam logic [15:0] RST_TIMEOUT     = 16'd300;
    localparam logic [7:0]  RST_MAX_LEN     = 8'd240;

    localparam logic [15:0] IDLE_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        PS_SYNC    = 3'd0,
        PS_BLK_LO  = 3'd1,
        PS_BLK_HI  = 3'd2,
        PS_LEN     = 3'd3,
        PS_PAYLOAD = 3'd4,
        PS_CSUM    = 3'd5
    } t_parse_state;

    typedef struct packed {
        logic [23:0] expected_payload_bytes;
        logic [15:0] timeout_ticks;
        logic [7:0]  max_payload_len;
    } t_cfg;

    typedef struct packed {
        logic        done_res;
        logic        timed_out;
        logic [23:0] payload_count;
        logic [31:0] wire_count;
        logic [15:0] sync_error_count;
        logic [15:0] checksum_error_count;
        logic [15:0] sequence_error_count;
        logic [15:0] elapsed_ticks;
    } t_result;

endpackage

@@ src/tfc_in_if.sv @@
interface tfc_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

@@ src/tfc_out_if.sv @@
interface tfc_out_if;
    logic        valid;
    logic        ready;
    logic        done_res;
    logic        timed_out;
    logic [23:0] payload_count;
    logic [31:0] wire_count;
    logic [15:0] sync_error_count;
    logic [15:0] checksum_error_count;
    logic [15:0] sequence_error_count;
    logic [15:0] elapsed_ticks;

    modport source (
        output valid, output done_res, output timed_out, output payload_count,
        output wire_count, output sync_error_count, output checksum_error_count,
        output sequence_error_count, output elapsed_ticks, input ready
    );
    modport sink (
        input valid, input done_res, input timed_out, input payload_count,
        input wire_count, input sync_error_count, input checksum_error_count,
        input sequence_error_count, input elapsed_ticks, output ready
    );
endinterface

@@ src/tfc_core.sv @@
`include "test_frame_checker_top_macros.svh"

module tfc_core
    import tfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic       i_operation,
    input  logic [7:0] i_rx_byte,
    input  t_cfg       i_cfg,
    output t_result    o_next
);

    t_parse_state r_parse_state, n_parse_state;
    logic [15:0]  r_frame_block, n_frame_block;
    logic [15:0]  r_next_block, n_next_block;
    logic [7:0]   r_frame_len, n_frame_len;
    logic [7:0]   r_byte_index, n_byte_index;
    logic [7:0]   r_running_sum, n_running_sum;
    logic [23:0]  r_payload_total, n_payload_total;
    logic [31:0]  r_wire_total, n_wire_total;
    logic [15:0]  r_sync_errs, n_sync_errs;
    logic [15:0]  r_sum_errs, n_sum_errs;
    logic [15:0]  r_order_errs, n_order_errs;
    logic [15:0]  r_idle_ticks, n_idle_ticks;
    logic [15:0]  r_tick_total, n_tick_total;
    logic         r_finished, n_finished;
    logic         r_timeout_hit, n_timeout_hit;

    logic         target_met;
    logic         live;
    logic         byte_en;
    logic         len_bad;
    logic [7:0]   idx_inc;
    logic [7:0]   exp_byte;
    logic [15:0]  idle_inc;

    assign target_met = r_payload_total >= i_cfg.expected_payload_bytes;
    assign live       = i_take && !r_finished && !target_met;
    assign byte_en    = live && (i_operation == OP_BYTE);
    assign len_bad    = (i_rx_byte == 8'd0) || (i_rx_byte > i_cfg.max_payload_len);
    assign idx_inc    = r_byte_index + 8'd1;
    assign exp_byte   = r_frame_block[7:0] + r_byte_index;
    assign idle_inc   = (r_idle_ticks != IDLE_MAX) ? r_idle_ticks + 16'd1 : r_idle_ticks;

    // frame parser next state
    always_comb begin
        n_parse_state = r_parse_state;
        if (byte_en) begin
            case (r_parse_state)
                PS_BLK_LO:  n_parse_state = PS_BLK_HI;
                PS_BLK_HI:  n_parse_state = PS_LEN;
                PS_LEN:     n_parse_state = len_bad ? PS_SYNC : PS_PAYLOAD;
                PS_PAYLOAD: n_parse_state = (idx_inc >= r_frame_len) ? PS_CSUM : PS_PAYLOAD;
                PS_CSUM:    n_parse_state = PS_SYNC;
                default:    n_parse_state = (i_rx_byte == SYNC_BYTE) ? PS_BLK_LO : PS_SYNC;
            endcase
        end
    end

    // datapath and counters
    always_comb begin
        n_frame_block   = r_frame_block;
        n_next_block    = r_next_block;
        n_frame_len     = r_frame_len;
        n_byte_index    = r_byte_index;
        n_running_sum   = r_running_sum;
        n_payload_total = r_payload_total;
        n_wire_total    = r_wire_total;
        n_sync_errs     = r_sync_errs;
        n_sum_errs      = r_sum_errs;
        n_order_errs    = r_order_errs;
        n_idle_ticks    = r_idle_ticks;
        n_tick_total    = r_tick_total;
        n_finished      = r_finished;
        n_timeout_hit   = r_timeout_hit;

        if (i_take && !r_finished && target_met) begin
            n_finished = 1'b1;
        end else if (live && (i_operation == OP_TICK)) begin
            n_tick_total = r_tick_total + 16'd1;
            n_idle_ticks = idle_inc;
            if (idle_inc > i_cfg.timeout_ticks) begin
                n_finished    = 1'b1;
                n_timeout_hit = 1'b1;
            end
        end else if (byte_en) begin
            n_wire_total = r_wire_total + 32'd1;
            n_idle_ticks = 16'd0;
            case (r_parse_state)
                PS_BLK_LO: begin
                    n_frame_block = {8'd0, i_rx_byte};
                    n_running_sum = r_running_sum + i_rx_byte;
                end
                PS_BLK_HI: begin
                    n_frame_block = {i_rx_byte, r_frame_block[7:0]};
                    n_running_sum = r_running_sum + i_rx_byte;
                end
                PS_LEN: begin
                    n_frame_len   = i_rx_byte;
                    n_running_sum = r_running_sum + i_rx_byte;
                    n_byte_index  = 8'd0;
                    if (len_bad) begin
                        n_sync_errs = r_sync_errs + 16'd1;
                    end else begin
                        if (r_frame_block != r_next_block) begin
                            n_order_errs = r_order_errs + 16'd1;
                        end
                        n_next_block = r_frame_block + 16'd1;
                    end
                end
                PS_PAYLOAD: begin
                    if (i_rx_byte != exp_byte) begin
                        n_order_errs = r_order_errs + 16'd1;
                    end
                    n_running_sum   = r_running_sum + i_rx_byte;
                    n_payload_total = r_payload_total + 24'd1;
                    n_byte_index    = idx_inc;
                end
                PS_CSUM: begin
                    if (i_rx_byte != r_running_sum) begin
                        n_sum_errs = r_sum_errs + 16'd1;
                    end
                end
                default: begin
                    if (i_rx_byte == SYNC_BYTE) begin
                        n_running_sum = i_rx_byte;
                    end else begin
                        n_sync_errs = r_sync_errs + 16'd1;
                    end
                end
            endcase
            if (n_payload_total >= i_cfg.expected_payload_bytes) begin
                n_finished = 1'b1;
            end
        end
    end

    // result as seen after this item
    always_comb begin
        o_next.done_res             = n_finished;
        o_next.timed_out            = n_timeout_hit;
        o_next.payload_count        = n_payload_total;
        o_next.wire_count           = n_wire_total;
        o_next.sync_error_count     = n_sync_errs;
        o_next.checksum_error_count = n_sum_errs;
        o_next.sequence_error_count = n_order_errs;
        o_next.elapsed_ticks        = (n_finished && (n_tick_total == 16'd0)) ?
                                      16'd1 : n_tick_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parse_state   <= PS_SYNC;
            r_frame_block   <= '0;
            r_next_block    <= '0;
            r_frame_len     <= '0;
            r_byte_index    <= '0;
            r_running_sum   <= '0;
            r_payload_total <= '0;
            r_wire_total    <= '0;
            r_sync_errs     <= '0;
            r_sum_errs      <= '0;
            r_order_errs    <= '0;
            r_idle_ticks    <= '0;
            r_tick_total    <= '0;
            r_finished      <= 1'b0;
            r_timeout_hit   <= 1'b0;
        end else begin
            r_parse_state   <= n_parse_state;
            r_frame_block   <= n_frame_block;
            r_next_block    <= n_next_block;
            r_frame_len     <= n_frame_len;
            r_byte_index    <= n_byte_index;
            r_running_sum   <= n_running_sum;
            r_payload_total <= n_payload_total;
            r_wire_total    <= n_wire_total;
            r_sync_errs     <= n_sync_errs;
            r_sum_errs      <= n_sum_errs;
            r_order_errs    <= n_order_errs;
            r_idle_ticks    <= n_idle_ticks;
            r_tick_total    <= n_tick_total;
            r_finished      <= n_finished;
            r_timeout_hit   <= n_timeout_hit;
        end
    end

    // once done, the run stays done
    `TFC_ASSERT_NEXT(a_done_sticky, i_clk, i_rst_n, r_finished, r_finished)
    // a timeout is always a finish
    `TFC_ASSERT_NOW(a_timeout_done, i_clk, i_rst_n, r_timeout_hit, r_finished)
    // inside a payload the index never reaches the length
    `TFC_ASSERT_NOW(a_index_bound, i_clk, i_rst_n, r_parse_state == PS_PAYLOAD,
        r_byte_index < r_frame_len)
    // counters move only on an accepted word
    `TFC_ASSERT_NEXT(a_wire_hold, i_clk, i_rst_n, !i_take, $stable(r_wire_total))

endmodule

@@ src/test_frame_checker_top.sv @@
// Test frame checker: receive side of a link test.
// Input channel (i_item): one word per handshake, either a received byte
// (operation 0, rx_byte valid) or one time tick (operation 1).
// Output channel (o_result): exactly one result word per input word, holding
// the done/timeout flags, payload and wire byte counts, the sync, checksum
// and sequence error counters, and the elapsed tick count.
// Config port: i_cfg_we/i_cfg_index/i_cfg_data write expected payload bytes
// (index 0), timeout ticks (1) and max payload length (2); write only while
// the block is idle.
// Output timing: a result word is valid in the cycle after its input word is taken.
// Throughput: one word per cycle while the output is not stalled; the frame
// parser state and all counters update together for each taken word, so the
// loop through the state registers is what sets that figure.
// Stall: the output register frees when o_result.ready is high, so input is
// taken in the same cycle the held result leaves; with the output stalled,
// i_item.ready drops until the result is taken.
// Reset (synchronous, active low): parser back to awaiting sync, all counters
// and flags cleared, config back to 16384 / 300 / 240, output empty.
module test_frame_checker_top
    import tfc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tfc_in_if.sink                i_item,
    tfc_out_if.source             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_result core_next;
    t_result r_result;
    logic    r_out_valid;
    logic    take;

    // take a word whenever the output slot is empty or is being drained
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign take         = i_item.valid && i_item.ready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_payload_bytes <= RST_EXP_PAYLOAD;
            r_cfg.timeout_ticks          <= RST_TIMEOUT;
            r_cfg.max_payload_len        <= RST_MAX_LEN;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EXP_PAYLOAD: r_cfg.expected_payload_bytes <= i_cfg_data;
                CFG_TIMEOUT:     r_cfg.timeout_ticks          <= i_cfg_data[15:0];
                CFG_MAX_LEN:     r_cfg.max_payload_len        <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    tfc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_operation (i_item.operation),
        .i_rx_byte   (i_item.rx_byte),
        .i_cfg       (r_cfg),
        .o_next      (core_next)
    );

    // output register: valid is control, the payload just loads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= core_next;
        end
    end

    assign o_result.valid                = r_out_valid;
    assign o_result.done_res             = r_result.done_res;
    assign o_result.timed_out            = r_result.timed_out;
    assign o_result.payload_count        = r_result.payload_count;
    assign o_result.wire_count           = r_result.wire_count;
    assign o_result.sync_error_count     = r_result.sync_error_count;
    assign o_result.checksum_error_count = r_result.checksum_error_count;
    assign o_result.sequence_error_count = r_result.sequence_error_count;
    assign o_result.elapsed_ticks        = r_result.elapsed_ticks;

endmodule
